// ===== src/lrf_pkg.sv =====
// Shared constants and types for the rectangle fill command stream block.
package lrf_pkg;

    // Display command opcodes.
    localparam logic [7:0] DCS_COLUMN_ADDR = 8'h2a;
    localparam logic [7:0] DCS_PAGE_ADDR   = 8'h2b;
    localparam logic [7:0] DCS_MEM_WRITE   = 8'h2c;

    // Request operations.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_BITS = 4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PANEL_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PANEL_HEIGHT = 4'd1;

    localparam int unsigned PANEL_BITS = 13;
    localparam logic [PANEL_BITS-1:0] PANEL_SIZE_RESET = 13'd320;

    // Header sequencer codes; STEP_PIXEL marks the pixel data phase.
    localparam logic [3:0] STEP_COL_CMD   = 4'd0;
    localparam logic [3:0] STEP_COL_SH    = 4'd1;
    localparam logic [3:0] STEP_COL_SL    = 4'd2;
    localparam logic [3:0] STEP_COL_EH    = 4'd3;
    localparam logic [3:0] STEP_COL_EL    = 4'd4;
    localparam logic [3:0] STEP_PAGE_CMD  = 4'd5;
    localparam logic [3:0] STEP_PAGE_SH   = 4'd6;
    localparam logic [3:0] STEP_PAGE_SL   = 4'd7;
    localparam logic [3:0] STEP_PAGE_EH   = 4'd8;
    localparam logic [3:0] STEP_PAGE_EL   = 4'd9;
    localparam logic [3:0] STEP_WRITE_CMD = 4'd10;
    localparam logic [3:0] STEP_PIXEL     = 4'd11;

    // Colour channel codes.
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef logic [PANEL_BITS-1:0] panel_size_t;
    typedef logic [23:0]           colour_t;

endpackage

// ===== src/lcd_rect_fill_command_stream_top.sv =====
// Rectangle fill command stream generator: header sequencer, pixel walker and handshakes.
// Path: a request is captured in the input register, and its byte (if any) is
// registered in the output register once that register is free or being emptied.
// Throughput: one request per cycle; in_stall is raised only while the output
// register holds a byte that the downstream side is stalling.
// Reset: rst_n clears the block to idle, with both panel sizes back at 320.
module lcd_rect_fill_command_stream_top
    import lrf_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Request channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic signed [15:0]        left_x,
    input  logic signed [15:0]        top_y,
    input  logic signed [15:0]        right_x,
    input  logic signed [15:0]        bottom_y,
    input  colour_t                   fill_color,
    // Byte channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                out_byte,
    output logic                      is_data,
    output logic                      group_end,
    output logic                      last_byte,
    // Configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [PANEL_BITS-1:0]     cfg_data
);

    typedef logic [COORD_BITS-1:0] coord_t;

    // Configuration registers.
    panel_size_t panel_width_reg;
    panel_size_t panel_height_reg;

    // Input register stage.
    logic               req_valid_reg;
    logic               req_valid_next;
    logic               req_op_reg;
    logic signed [15:0] req_left_reg;
    logic signed [15:0] req_top_reg;
    logic signed [15:0] req_right_reg;
    logic signed [15:0] req_bottom_reg;
    colour_t            req_colour_reg;

    // Stream state.
    logic       busy_reg;
    logic       busy_next;
    logic [3:0] step_reg;
    logic [3:0] step_next;
    coord_t     clip_left_reg;
    coord_t     clip_left_next;
    coord_t     clip_top_reg;
    coord_t     clip_top_next;
    coord_t     clip_right_reg;
    coord_t     clip_right_next;
    coord_t     clip_bottom_reg;
    coord_t     clip_bottom_next;
    colour_t    colour_reg;
    colour_t    colour_next;
    coord_t     column_reg;
    coord_t     column_next;
    coord_t     row_reg;
    coord_t     row_next;
    logic [1:0] channel_reg;
    logic [1:0] channel_next;

    // Output register.
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       is_data_reg;
    logic       is_data_next;
    logic       group_end_reg;
    logic       group_end_next;
    logic       last_byte_reg;
    logic       last_byte_next;

    // Clipper results.
    coord_t c_left;
    coord_t c_top;
    coord_t c_right;
    coord_t c_bottom;
    logic   c_empty;

    logic        accept;
    logic        fire;
    logic [15:0] lo_word;
    logic [15:0] hi_word;
    logic        finish;

    // The held request is processed as soon as the output register is free or
    // is being emptied this cycle; a start request never needs the slot but
    // takes the same path so that order is kept trivially.
    assign fire     = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_data   = is_data_reg;
    assign group_end = group_end_reg;
    assign last_byte = last_byte_reg;

    lrf_clip #(
        .COORD_BITS (COORD_BITS)
    ) u_clip (
        .panel_width  (panel_width_reg),
        .panel_height (panel_height_reg),
        .left_x       (req_left_reg),
        .top_y        (req_top_reg),
        .right_x      (req_right_reg),
        .bottom_y     (req_bottom_reg),
        .clip_left    (c_left),
        .clip_top     (c_top),
        .clip_right   (c_right),
        .clip_bottom  (c_bottom),
        .empty        (c_empty)
    );

    // Address parameters: the column window for the first command, the page
    // window for the second.
    assign lo_word = (step_reg < STEP_PAGE_CMD) ? 16'(clip_left_reg)  : 16'(clip_top_reg);
    assign hi_word = (step_reg < STEP_PAGE_CMD) ? 16'(clip_right_reg) : 16'(clip_bottom_reg);

    // The last pixel byte is the blue byte of the bottom right pixel.
    assign finish = (channel_reg == CH_BLUE) && (column_reg >= clip_right_reg) &&
                    (row_reg >= clip_bottom_reg);

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (fire)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        busy_next        = busy_reg;
        step_next        = step_reg;
        clip_left_next   = clip_left_reg;
        clip_top_next    = clip_top_reg;
        clip_right_next  = clip_right_reg;
        clip_bottom_next = clip_bottom_reg;
        colour_next      = colour_reg;
        column_next      = column_reg;
        row_next         = row_reg;
        channel_next     = channel_reg;

        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        is_data_next   = is_data_reg;
        group_end_next = group_end_reg;
        last_byte_next = last_byte_reg;

        if (fire)
        begin
            if (req_op_reg == OP_START)
            begin
                // A start while a stream is running is dropped.
                if (!busy_reg && !c_empty)
                begin
                    busy_next        = 1'b1;
                    step_next        = STEP_COL_CMD;
                    clip_left_next   = c_left;
                    clip_top_next    = c_top;
                    clip_right_next  = c_right;
                    clip_bottom_next = c_bottom;
                    colour_next      = req_colour_reg;
                    column_next      = c_left;
                    row_next         = c_top;
                    channel_next     = CH_RED;
                end
            end
            else if (busy_reg)
            begin
                out_valid_next = 1'b1;
                is_data_next   = 1'b1;
                group_end_next = 1'b0;
                last_byte_next = 1'b0;
                if (step_reg != STEP_PIXEL)
                begin
                    step_next = step_reg + 4'd1;
                end
                case (step_reg)
                    STEP_COL_CMD:
                    begin
                        out_byte_next  = DCS_COLUMN_ADDR;
                        is_data_next   = 1'b0;
                        group_end_next = 1'b1;
                    end
                    STEP_PAGE_CMD:
                    begin
                        out_byte_next  = DCS_PAGE_ADDR;
                        is_data_next   = 1'b0;
                        group_end_next = 1'b1;
                    end
                    STEP_WRITE_CMD:
                    begin
                        out_byte_next  = DCS_MEM_WRITE;
                        is_data_next   = 1'b0;
                        group_end_next = 1'b1;
                    end
                    STEP_COL_SH, STEP_PAGE_SH:
                    begin
                        out_byte_next = lo_word[15:8];
                    end
                    STEP_COL_SL, STEP_PAGE_SL:
                    begin
                        out_byte_next = lo_word[7:0];
                    end
                    STEP_COL_EH, STEP_PAGE_EH:
                    begin
                        out_byte_next = hi_word[15:8];
                    end
                    STEP_COL_EL, STEP_PAGE_EL:
                    begin
                        out_byte_next  = hi_word[7:0];
                        group_end_next = 1'b1;
                    end
                    default:
                    begin
                        // Pixel data: red, green, blue for each pixel in turn.
                        case (channel_reg)
                            CH_RED:   out_byte_next = colour_reg[23:16];
                            CH_GREEN: out_byte_next = colour_reg[15:8];
                            default:  out_byte_next = colour_reg[7:0];
                        endcase
                        group_end_next = finish;
                        last_byte_next = finish;
                        if (finish)
                        begin
                            busy_next    = 1'b0;
                            step_next    = STEP_COL_CMD;
                            channel_next = CH_RED;
                        end
                        else if (channel_reg != CH_BLUE)
                        begin
                            channel_next = channel_reg + 2'd1;
                        end
                        else
                        begin
                            channel_next = CH_RED;
                            if (column_reg >= clip_right_reg)
                            begin
                                column_next = clip_left_reg;
                                row_next    = row_reg + coord_t'(1);
                            end
                            else
                            begin
                                column_next = column_reg + coord_t'(1);
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_width_reg  <= PANEL_SIZE_RESET;
            panel_height_reg <= PANEL_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_PANEL_WIDTH)
            begin
                panel_width_reg <= cfg_data;
            end
            else if (cfg_index == CFG_PANEL_HEIGHT)
            begin
                panel_height_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg   <= 1'b0;
            busy_reg        <= 1'b0;
            step_reg        <= STEP_COL_CMD;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= '0;
            clip_bottom_reg <= '0;
            column_reg      <= '0;
            row_reg         <= '0;
            channel_reg     <= CH_RED;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            req_valid_reg   <= req_valid_next;
            busy_reg        <= busy_next;
            step_reg        <= step_next;
            clip_left_reg   <= clip_left_next;
            clip_top_reg    <= clip_top_next;
            clip_right_reg  <= clip_right_next;
            clip_bottom_reg <= clip_bottom_next;
            column_reg      <= column_next;
            row_reg         <= row_next;
            channel_reg     <= channel_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_op_reg     <= operation;
            req_left_reg   <= left_x;
            req_top_reg    <= top_y;
            req_right_reg  <= right_x;
            req_bottom_reg <= bottom_y;
            req_colour_reg <= fill_color;
        end
        colour_reg     <= colour_next;
        out_byte_reg   <= out_byte_next;
        is_data_reg    <= is_data_next;
        group_end_reg  <= group_end_next;
        last_byte_reg  <= last_byte_next;
    end

    // The header sequencer is parked at its first step whenever no stream runs.
    a_idle_step : assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (step_reg == STEP_COL_CMD) && (channel_reg == CH_RED))
        else $error("header step not parked while idle");

    // The pixel walker never leaves the clipped window.
    a_walk_bounds : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (column_reg <= clip_right_reg) && (row_reg <= clip_bottom_reg) &&
                     (column_reg >= clip_left_reg))
        else $error("pixel position outside the clipped window");

    // The final byte is a data byte that ends its chip-select group, and
    // producing it leaves the block idle.
    a_last_byte : assert property (@(posedge clk) disable iff (!rst_n)
        fire && busy_reg && (req_op_reg == OP_TICK) && finish && (step_reg == STEP_PIXEL)
        |=> out_valid_reg && last_byte_reg && group_end_reg && is_data_reg && !busy_reg)
        else $error("final pixel byte malformed");

endmodule

// ===== src/lrf_clip.sv =====
// Clips a requested rectangle to the panel and flags an empty result.
module lrf_clip
    import lrf_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  panel_size_t             panel_width,
    input  panel_size_t             panel_height,
    input  logic signed [15:0]      left_x,
    input  logic signed [15:0]      top_y,
    input  logic signed [15:0]      right_x,
    input  logic signed [15:0]      bottom_y,
    output logic [COORD_BITS-1:0]   clip_left,
    output logic [COORD_BITS-1:0]   clip_top,
    output logic [COORD_BITS-1:0]   clip_right,
    output logic [COORD_BITS-1:0]   clip_bottom,
    output logic                    empty
);

    logic        [17:0] cap;
    logic        [17:0] eff_w;
    logic        [17:0] eff_h;
    logic signed [17:0] lim_x;
    logic signed [17:0] lim_y;
    logic signed [17:0] l_ext;
    logic signed [17:0] t_ext;
    logic signed [17:0] r_ext;
    logic signed [17:0] b_ext;
    logic signed [17:0] l_clip;
    logic signed [17:0] t_clip;
    logic signed [17:0] r_clip;
    logic signed [17:0] b_clip;

    always_comb
    begin
        cap   = 18'd1 << COORD_BITS;
        eff_w = (18'(panel_width) > cap) ? cap : 18'(panel_width);
        eff_h = (18'(panel_height) > cap) ? cap : 18'(panel_height);
        lim_x = $signed(eff_w) - 18'sd1;
        lim_y = $signed(eff_h) - 18'sd1;

        l_ext = 18'(left_x);
        t_ext = 18'(top_y);
        r_ext = 18'(right_x);
        b_ext = 18'(bottom_y);

        l_clip = (l_ext < 18'sd0) ? 18'sd0 : l_ext;
        t_clip = (t_ext < 18'sd0) ? 18'sd0 : t_ext;
        r_clip = (r_ext > lim_x) ? lim_x : r_ext;
        b_clip = (b_ext > lim_y) ? lim_y : b_ext;

        empty = (eff_w == 18'd0) || (eff_h == 18'd0) ||
                (r_clip < l_clip) || (b_clip < t_clip);

        // Only meaningful when the rectangle is not empty, when all lie in range.
        clip_left   = l_clip[COORD_BITS-1:0];
        clip_top    = t_clip[COORD_BITS-1:0];
        clip_right  = r_clip[COORD_BITS-1:0];
        clip_bottom = b_clip[COORD_BITS-1:0];
    end

endmodule

// ===== test/lcd_rect_fill_command_stream_top_test.sv =====
// Self-checking testbench for the rectangle fill command stream block.
module lcd_rect_fill_command_stream_top_test;

    import lrf_pkg::*;

    // Coordinate width of the block under test, and the largest panel size it can clip to.
    localparam int COORD_BITS  = 12;
    localparam int COORD_LIMIT = 1 << COORD_BITS;
    // Cycles with no handshake on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Only the first few mismatches are printed in full.
    localparam int REPORT_LIMIT = 10;

    // One byte of the display stream, as the block should present it.
    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       group_end;
        logic       last_byte;
    } stream_byte_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      operation = OP_TICK;
    logic signed [15:0]        left_x = '0;
    logic signed [15:0]        top_y = '0;
    logic signed [15:0]        right_x = '0;
    logic signed [15:0]        bottom_y = '0;
    colour_t                   fill_color = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [7:0]                out_byte;
    logic                      is_data;
    logic                      group_end;
    logic                      last_byte;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_PANEL_WIDTH;
    logic [PANEL_BITS-1:0]     cfg_data = '0;

    // Probabilities, in percent, that the sender idles and the receiver stalls in a cycle.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Bytes the block owes us, oldest first.
    stream_byte_t expected_bytes[$];
    int fault_count = 0;
    int quiet_cycles = 0;

    // Our own copy of the block's state: the panel registers and the fill in progress.
    panel_size_t panel_w = PANEL_SIZE_RESET;
    panel_size_t panel_h = PANEL_SIZE_RESET;
    logic        fill_busy = 1'b0;
    logic [3:0]  fill_step = STEP_COL_CMD;
    logic [11:0] fill_left = '0;
    logic [11:0] fill_top = '0;
    logic [11:0] fill_right = '0;
    logic [11:0] fill_bottom = '0;
    colour_t     fill_colour = '0;
    logic [11:0] pixel_col = '0;
    logic [11:0] pixel_row = '0;
    logic [1:0]  pixel_channel = CH_RED;

    lcd_rect_fill_command_stream_top #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .operation(operation),
        .left_x(left_x),
        .top_y(top_y),
        .right_x(right_x),
        .bottom_y(bottom_y),
        .fill_color(fill_color),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .is_data(is_data),
        .group_end(group_end),
        .last_byte(last_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // The receiver stalls at random, independently of anything the block does.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic stream_byte_t make_byte(input logic [7:0] value, input logic is_data,
                                               input logic group_end, input logic last_byte);
        stream_byte_t b;
        b.value = value;
        b.is_data = is_data;
        b.group_end = group_end;
        b.last_byte = last_byte;
        return b;
    endfunction

    // Panel sizes above the coordinate range clip as if they were exactly at its limit.
    function automatic int clip_limit(input panel_size_t size);
        return (int'(size) > COORD_LIMIT) ? COORD_LIMIT : int'(size);
    endfunction

    // Advances our copy of the block by one accepted request and queues the byte it
    // should produce, if any.  A start never produces a byte; a tick produces one
    // exactly while a fill is in progress.
    task automatic advance_fill(input logic op, input logic signed [15:0] l,
                                input logic signed [15:0] t, input logic signed [15:0] r,
                                input logic signed [15:0] b, input colour_t colour);
        int           ew;
        int           eh;
        int           cl;
        int           ct;
        int           cr;
        int           cb;
        logic [11:0]  lo;
        logic [11:0]  hi;
        logic [7:0]   shade;
        logic         fin;
        stream_byte_t nb;
        if (op == OP_START)
        begin
            // A start while a fill is running is simply dropped.
            if (!fill_busy)
            begin
                ew = clip_limit(panel_w);
                eh = clip_limit(panel_h);
                cl = l;
                ct = t;
                cr = r;
                cb = b;
                if (cl < 0) cl = 0;
                if (ct < 0) ct = 0;
                if (cr > ew - 1) cr = ew - 1;
                if (cb > eh - 1) cb = eh - 1;
                // An empty rectangle leaves the block idle with nothing to send.
                if (!(ew == 0 || eh == 0 || cr < cl || cb < ct))
                begin
                    fill_left = 12'(cl);
                    fill_top = 12'(ct);
                    fill_right = 12'(cr);
                    fill_bottom = 12'(cb);
                    fill_colour = colour;
                    pixel_col = 12'(cl);
                    pixel_row = 12'(ct);
                    pixel_channel = CH_RED;
                    fill_step = STEP_COL_CMD;
                    fill_busy = 1'b1;
                end
            end
        end
        else if (fill_busy)
        begin
            if (fill_step != STEP_PIXEL)
            begin
                lo = (fill_step < STEP_PAGE_CMD) ? fill_left : fill_top;
                hi = (fill_step < STEP_PAGE_CMD) ? fill_right : fill_bottom;
                case (fill_step)
                    STEP_COL_CMD:   nb = make_byte(DCS_COLUMN_ADDR, 1'b0, 1'b1, 1'b0);
                    STEP_PAGE_CMD:  nb = make_byte(DCS_PAGE_ADDR, 1'b0, 1'b1, 1'b0);
                    STEP_WRITE_CMD: nb = make_byte(DCS_MEM_WRITE, 1'b0, 1'b1, 1'b0);
                    STEP_COL_SH, STEP_PAGE_SH:
                        nb = make_byte({4'h0, lo[11:8]}, 1'b1, 1'b0, 1'b0);
                    STEP_COL_SL, STEP_PAGE_SL:
                        nb = make_byte(lo[7:0], 1'b1, 1'b0, 1'b0);
                    STEP_COL_EH, STEP_PAGE_EH:
                        nb = make_byte({4'h0, hi[11:8]}, 1'b1, 1'b0, 1'b0);
                    default:
                        nb = make_byte(hi[7:0], 1'b1, 1'b1, 1'b0);
                endcase
                fill_step = fill_step + 4'd1;
            end
            else
            begin
                case (pixel_channel)
                    CH_RED:   shade = fill_colour[23:16];
                    CH_GREEN: shade = fill_colour[15:8];
                    default:  shade = fill_colour[7:0];
                endcase
                fin = (pixel_channel >= CH_BLUE) && (pixel_col >= fill_right)
                      && (pixel_row >= fill_bottom);
                nb = make_byte(shade, 1'b1, fin, fin);
                if (fin)
                begin
                    fill_busy = 1'b0;
                    fill_step = STEP_COL_CMD;
                    pixel_channel = CH_RED;
                end
                else if (pixel_channel < CH_BLUE)
                begin
                    pixel_channel = pixel_channel + 2'd1;
                end
                else
                begin
                    pixel_channel = CH_RED;
                    if (pixel_col >= fill_right)
                    begin
                        pixel_col = fill_left;
                        pixel_row = pixel_row + 12'd1;
                    end
                    else
                    begin
                        pixel_col = pixel_col + 12'd1;
                    end
                end
            end
            expected_bytes.push_back(nb);
        end
    endtask

    // Offers one request, after a random number of idle cycles, and holds it until taken.
    task automatic send_request(input logic op, input logic signed [15:0] l,
                                input logic signed [15:0] t, input logic signed [15:0] r,
                                input logic signed [15:0] b, input colour_t colour);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        left_x <= l;
        top_y <= t;
        right_x <= r;
        bottom_y <= b;
        fill_color <= colour;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        advance_fill(op, l, t, r, b, colour);
    endtask

    // A tick carries random coordinates and colour, which the block must disregard.
    task automatic send_tick();
        send_request(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     24'($urandom));
    endtask

    // Ticks until the fill in progress, if any, has been sent in full.
    task automatic drain_fill();
        while (fill_busy)
        begin
            send_tick();
        end
    endtask

    // The sender goes quiet until every owed byte has come out.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_bytes.size() != 0);
    endtask

    // Idle in the full sense: nothing owed, and time for a byteless request to clear
    // the two register stages.
    task automatic wait_for_quiet();
        hold_until_drained();
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input panel_size_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (index == CFG_PANEL_WIDTH)
            panel_w = value;
        else if (index == CFG_PANEL_HEIGHT)
            panel_h = value;
        @(posedge clk);
    endtask

    // A coordinate near one of the panel's edges, or anywhere within a little of it.
    function automatic int pick_near(input int size);
        int v;
        if ($urandom_range(0, 3) == 0)
            v = ($urandom_range(0, 1) ? size : 0) + int'($urandom_range(0, 4)) - 2;
        else
            v = int'($urandom_range(0, size + 1)) - 2;
        return v;
    endfunction

    // A coordinate drawn from the corners of the 16-bit range and of the panel.
    function automatic int pick_extreme(input int size);
        int v;
        case ($urandom_range(0, 6))
            0:       v = -32768;
            1:       v = -1;
            2:       v = 0;
            3:       v = size - 1;
            4:       v = size;
            5:       v = 32767;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return v;
    endfunction

    // Mostly small rectangles near the panel so that fills finish quickly; on small
    // panels also fully random coordinates and extreme corners.
    task automatic pick_rect(output logic signed [15:0] l, output logic signed [15:0] t,
                             output logic signed [15:0] r, output logic signed [15:0] b);
        int ew;
        int eh;
        int x0;
        int y0;
        int mode;
        ew = clip_limit(panel_w);
        eh = clip_limit(panel_h);
        mode = $urandom_range(0, 99);
        if (ew * eh <= 64 && mode >= 70)
        begin
            if (mode < 85)
            begin
                l = 16'($urandom);
                t = 16'($urandom);
                r = 16'($urandom);
                b = 16'($urandom);
            end
            else
            begin
                l = 16'(pick_extreme(ew));
                t = 16'(pick_extreme(eh));
                r = 16'(pick_extreme(ew));
                b = 16'(pick_extreme(eh));
            end
        end
        else
        begin
            x0 = pick_near(ew);
            y0 = pick_near(eh);
            l = 16'(x0);
            t = 16'(y0);
            r = 16'(x0 + int'($urandom_range(0, 3)) - 1);
            b = 16'(y0 + int'($urandom_range(0, 3)) - 1);
        end
    endtask

    // Straight after reset the panel is 320 by 320: a rectangle running off the
    // bottom right corner must clip to its last column and row.  A tick while idle
    // and a start in the middle of a fill must both be ignored.
    task automatic test_reset_defaults();
        send_tick();
        send_request(OP_START, 16'sd318, 16'sd319, 16'sh7fff, 16'sh7fff, 24'hffffff);
        send_tick();
        send_request(OP_START, 16'sd0, 16'sd0, 16'sd5, 16'sd5, 24'h123456);
        drain_fill();
    endtask

    // Empty rectangles, corners at the negative extreme, and a left edge past the panel.
    task automatic test_clipping_cases();
        send_request(OP_START, 16'sd5, 16'sd0, 16'sd4, 16'sd0, 24'h00ff00);
        send_tick();
        send_request(OP_START, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 24'h000000);
        drain_fill();
        send_request(OP_START, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 24'hff00ff);
        send_request(OP_START, 16'sd320, 16'sd0, 16'sd400, 16'sd3, 24'h0000ff);
        send_tick();
    endtask

    // A zero-sized panel takes nothing; an oversized one clips at the coordinate limit;
    // a write to an index past the register list changes nothing.
    task automatic test_panel_extremes();
        wait_for_quiet();
        write_register(CFG_PANEL_WIDTH, '0);
        send_request(OP_START, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 24'haaaaaa);
        send_tick();
        wait_for_quiet();
        write_register(CFG_PANEL_WIDTH, '1);
        write_register(CFG_PANEL_HEIGHT, panel_size_t'(COORD_LIMIT));
        send_request(OP_START, 16'sd4095, 16'sd4095, 16'sh7fff, 16'sh7fff, 24'h5aa53c);
        drain_fill();
        wait_for_quiet();
        write_register(CFG_PANEL_WIDTH, panel_size_t'(2));
        write_register(CFG_PANEL_HEIGHT, panel_size_t'(1));
        write_register(CFG_PANEL_HEIGHT + CFG_INDEX_BITS'($urandom_range(1, 14)),
                       panel_size_t'($urandom));
        send_request(OP_START, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 24'hc3e17f);
        drain_fill();
    endtask

    // Mostly well-formed fills with random content, broken up by ticks while idle,
    // starts while busy and the odd pause until every owed byte has come out.
    task automatic test_random_fills(input int send_pct, input int stall_pct,
                                     input panel_size_t w, input panel_size_t h,
                                     input int budget);
        int done;
        int roll;
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
        wait_for_quiet();
        write_register(CFG_PANEL_WIDTH, w);
        write_register(CFG_PANEL_HEIGHT, h);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < budget)
        begin
            roll = $urandom_range(0, 99);
            if (!fill_busy)
            begin
                if (roll < 85)
                begin
                    pick_rect(l, t, r, b);
                    send_request(OP_START, l, t, r, b, 24'($urandom));
                    done++;
                end
                else
                begin
                    send_tick();
                end
            end
            else if (roll < 95)
            begin
                send_tick();
                done++;
            end
            else if (roll < 98)
            begin
                send_request(OP_START, 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 24'($urandom));
            end
            else
            begin
                hold_until_drained();
            end
        end
        drain_fill();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Every byte taken from the block is checked against the oldest one owed.
    always @(posedge clk)
    begin : check_bytes
        stream_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected byte %02h is_data %0b group_end %0b last_byte %0b",
                             out_byte, is_data, group_end, last_byte);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value || is_data !== want.is_data
                    || group_end !== want.group_end || last_byte !== want.last_byte)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("byte mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                                 want.value, want.is_data, want.group_end, want.last_byte,
                                 out_byte, is_data, group_end, last_byte);
                end
            end
        end
    end

    // The watchdog restarts whenever any channel completes a handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_clipping_cases();
        test_panel_extremes();
        // No idling, then a one-pixel panel with a slow sender, the largest panel with
        // a slow receiver, and a small panel with light idling on both sides.
        test_random_fills(0, 0, panel_size_t'(6), panel_size_t'(4), 480);
        test_random_fills(65, 0, panel_size_t'(1), panel_size_t'(1), 480);
        test_random_fills(0, 65, panel_size_t'(COORD_LIMIT), panel_size_t'(COORD_LIMIT), 480);
        test_random_fills(11, 11, panel_size_t'(7), panel_size_t'(3), 480);

        wait_for_quiet();
        repeat (6) @(posedge clk);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
